### hw/rtl/isme_pkg.sv
// Shared types and constants for the multi-tap echo block.
// Used by every module of the block except the generic RAM; has no dependencies.
`timescale 1ns / 1ps
package isme_pkg;

  localparam int DELAY_DEPTH = 16384;
  localparam int NUM_TAPS    = 7;

  localparam int ADDR_W    = $clog2(DELAY_DEPTH);
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int DELAY_W   = 14;
  localparam int GAIN_LSB  = DELAY_W;
  localparam int TAP_W     = DELAY_W + GAIN_W;
  localparam int CFG_IDX_W = $clog2(NUM_TAPS + 1);
  localparam int TAP_CNT_W = $clog2(NUM_TAPS + 1);

  // widths for read address arithmetic and delay range checks
  localparam int XW    = ADDR_W + 2;
  localparam int CMP_W = (ADDR_W + 1 > DELAY_W) ? ADDR_W + 1 : DELAY_W;

  // product, accumulator and rounding widths
  localparam int PROD_W    = SAMPLE_W + GAIN_W;
  localparam int ACC_W     = PROD_W + $clog2(NUM_TAPS + 1);
  localparam int FRAC_W    = GAIN_W - 1;
  localparam int RND_W     = ACC_W + 1 - FRAC_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_DIRECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGES_ON  = CFG_IDX_W'(NUM_TAPS);

  // register reset values
  localparam logic [TAP_W-1:0] TAP_DIRECT_RST = TAP_W'(32767);
  localparam logic [TAP_W-1:0] TAP_IMAGE_RST  = '0;
  localparam logic             IMAGES_ON_RST  = 1'b1;

  // per-tap control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic              clear;
    logic              issue;
    logic              zero;
    logic [GAIN_W-1:0] gain;
  } mac_ctl_t;

endpackage

### hw/rtl/isme_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module isme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/isme_cfg.sv
// Tap and mode registers with the tap select mux.
// Depends on isme_pkg.
`timescale 1ns / 1ps
module isme_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [isme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isme_pkg::TAP_W-1:0]      cfg_data,
  input  logic [isme_pkg::TAP_CNT_W-1:0]  sel,
  output logic [isme_pkg::TAP_W-1:0]      tap_word,
  output logic                            images_on
);

  logic [isme_pkg::TAP_W-1:0] tap_reg [isme_pkg::NUM_TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < isme_pkg::NUM_TAPS; i++) begin
        tap_reg[i] <= isme_pkg::TAP_IMAGE_RST;
      end
      tap_reg[isme_pkg::REG_TAP_DIRECT] <= isme_pkg::TAP_DIRECT_RST;
      images_on <= isme_pkg::IMAGES_ON_RST;
    end else if (cfg_we) begin
      if (cfg_index < isme_pkg::REG_IMAGES_ON) begin
        tap_reg[cfg_index] <= cfg_data;
      end else if (cfg_index == isme_pkg::REG_IMAGES_ON) begin
        images_on <= cfg_data[0];
      end
    end
  end

  assign tap_word = tap_reg[sel];

endmodule

### hw/rtl/isme_mac.sv
// Tap multiply-accumulate pipeline with final rounding and saturation.
// Depends on isme_pkg; takes read data from the delay RAM.
`timescale 1ns / 1ps
module isme_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  isme_pkg::mac_ctl_t             ctl,
  input  logic [isme_pkg::SAMPLE_W-1:0]  rdata,
  output logic                           busy,
  output logic [isme_pkg::SAMPLE_W-1:0]  result
);

  logic                          vld1;
  logic                          zero1;
  logic [isme_pkg::GAIN_W-1:0]   gain1;
  logic                          vld2;
  logic [isme_pkg::PROD_W-1:0]   prod;
  logic [isme_pkg::ACC_W-1:0]    acc;
  logic [isme_pkg::ACC_W:0]      rsum;
  logic [isme_pkg::RND_W-1:0]    rnd;
  logic                          fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= ctl.issue;
      vld2 <= vld1;
    end
  end

  // stage 1 holds the tap info alongside the RAM read
  always_ff @(posedge clk) begin
    zero1 <= ctl.zero;
    gain1 <= ctl.gain;
  end

  always_ff @(posedge clk) begin
    if (vld1) begin
      prod <= zero1 ? '0
                    : isme_pkg::PROD_W'($signed(rdata) * $signed(gain1));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (vld2) begin
      acc <= acc + {{(isme_pkg::ACC_W - isme_pkg::PROD_W){prod[isme_pkg::PROD_W-1]}}, prod};
    end
  end

  // round half up, then saturate to the sample range
  always_comb begin
    rsum = {acc[isme_pkg::ACC_W-1], acc} +
           (isme_pkg::ACC_W + 1)'(1 << (isme_pkg::FRAC_W - 1));
    rnd  = rsum[isme_pkg::ACC_W:isme_pkg::FRAC_W];
    fits = (rnd[isme_pkg::RND_W-1:isme_pkg::SAMPLE_W-1] == '0) ||
           (rnd[isme_pkg::RND_W-1:isme_pkg::SAMPLE_W-1] == '1);
    if (fits) begin
      result = rnd[isme_pkg::SAMPLE_W-1:0];
    end else if (rnd[isme_pkg::RND_W-1]) begin
      result = {1'b1, {(isme_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(isme_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  assign busy = vld1 | vld2;

endmodule

### hw/rtl/image_source_multitap_echo_top.sv
// Multi-tap echo: one sample in, one saturated tap sum out.
// A new sample is accepted only in the idle state, after the previous result has gone to the output.
// The single read port of the delay RAM is shared by all taps, one tap read per cycle.
// Reset: synchronous; registers return to defaults, write position to zero, unwritten
// delay entries read as zero through the fill tracking, no clearing pass.
`timescale 1ns / 1ps
module image_source_multitap_echo_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [15:0] in_sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // [15:0] out_sample
  input  logic                           cfg_we,
  input  logic [isme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [isme_pkg::TAP_W-1:0]     cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                      state, state_next;
  logic [isme_pkg::TAP_CNT_W-1:0]  cnt;
  logic [isme_pkg::TAP_CNT_W-1:0]  ntaps;
  logic [isme_pkg::ADDR_W-1:0]     wp;
  logic                            wrapped;
  logic [isme_pkg::TAP_W-1:0]      tap_word;
  logic                            images_on;
  logic [isme_pkg::DELAY_W-1:0]    delay;
  logic [isme_pkg::XW-1:0]         rd_ext;
  logic [isme_pkg::ADDR_W-1:0]     raddr;
  logic                            out_range;
  logic                            unwritten;
  logic [isme_pkg::SAMPLE_W-1:0]   rdata;
  logic [isme_pkg::SAMPLE_W-1:0]   result;
  logic                            busy;
  logic                            in_acc;
  logic                            issue;
  logic                            finish;
  isme_pkg::mac_ctl_t              ctl;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign issue    = (state == S_READ);
  assign finish   = (state == S_DRAIN) && !busy && (!m_tvalid || m_tready);

  isme_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sel       (cnt),
    .tap_word  (tap_word),
    .images_on (images_on)
  );

  // read address: wp - delay modulo depth
  always_comb begin
    delay  = tap_word[isme_pkg::DELAY_W-1:0];
    rd_ext = isme_pkg::XW'(wp) + isme_pkg::XW'(isme_pkg::DELAY_DEPTH) -
             isme_pkg::XW'(delay);
    if (rd_ext >= isme_pkg::XW'(isme_pkg::DELAY_DEPTH)) begin
      rd_ext = rd_ext - isme_pkg::XW'(isme_pkg::DELAY_DEPTH);
    end
    raddr     = rd_ext[isme_pkg::ADDR_W-1:0];
    out_range = isme_pkg::CMP_W'(delay) >= isme_pkg::CMP_W'(isme_pkg::DELAY_DEPTH);
    // before the first wrap, entries above wp were never written
    unwritten = !wrapped && (isme_pkg::CMP_W'(delay) > isme_pkg::CMP_W'(wp));
  end

  always_comb begin
    ctl.clear = in_acc;
    ctl.issue = issue;
    ctl.zero  = out_range || unwritten;
    ctl.gain  = tap_word[isme_pkg::TAP_W-1:isme_pkg::GAIN_LSB];
  end

  isme_ram #(
    .WIDTH (isme_pkg::SAMPLE_W),
    .DEPTH (isme_pkg::DELAY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp),
    .wdata (s_tdata),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  isme_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rdata  (rdata),
    .busy   (busy),
    .result (result)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_READ;
      end
      S_READ: begin
        if (cnt == ntaps - 1'b1) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      ntaps    <= isme_pkg::TAP_CNT_W'(1);
      wp       <= '0;
      wrapped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        cnt   <= '0;
        ntaps <= images_on ? isme_pkg::TAP_CNT_W'(isme_pkg::NUM_TAPS)
                           : isme_pkg::TAP_CNT_W'(1);
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (finish) begin
        // advance write position once the item is done
        if (wp == isme_pkg::ADDR_W'(isme_pkg::DELAY_DEPTH - 1)) begin
          wp      <= '0;
          wrapped <= 1'b1;
        end else begin
          wp <= wp + 1'b1;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= result;
    end
  end

endmodule

### hw/rtl/isme_check.sv
// Port-level checker for the multi-tap echo top level, bound to it below.
// Depends on isme_pkg for port widths.
`timescale 1ns / 1ps
module isme_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [15:0]                    s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [15:0]                    m_tdata,
  input logic                           cfg_we,
  input logic [isme_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [isme_pkg::TAP_W-1:0]     cfg_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // one item in flight: no new input right after an accepted word
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in work");

  // no result can appear in the cycle after an accept
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared too early");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind image_source_multitap_echo_top isme_check u_check (.*);
